[hw/rtl/ita_pkg.sv]
// ita_pkg: widths, opcodes, character codes and the digit-to-ASCII function
// shared by the integer to ASCII converter. Depends on nothing.
package ita_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_VALUE_W  = 32;
  localparam int OPCODE_W    = 3;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // decimal digits of 2**VALUE_WIDTH-1 (log10(2) ~ 1233/4096)
  localparam int DEC_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
  localparam int NDIG        = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_W       = NDIG * 4;
  localparam int HEX_W       = HEX_DIGITS * 4;
  localparam int CNT_W       = $clog2(NDIG + 1);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [OPCODE_W-1:0] OP_SDEC = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_UDEC = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_HEXL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_HEXU = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PTR  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  localparam logic [3:0] DEC_RADIX = 4'd10;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base_ch;
    begin
      base_ch = upper ? CH_UPA : CH_LOWA;
      if (d < DEC_RADIX) digit_char = CH_ZERO + CHAR_W'(d);
      else digit_char = base_ch + CHAR_W'(d - DEC_RADIX);
    end
  endfunction

endpackage

[hw/rtl/integer_to_ascii_converter.sv]
// integer_to_ascii_converter: turns one number and an opcode into ASCII text,
// one character per output item. Depends on ita_pkg.
//
// Usage
//   Input stream: in_tdata carries the value and the opcode (0 signed decimal,
//   1 unsigned decimal, 2 hex lower, 3 hex upper, 4 pointer "0x"+hex lower).
//   Opcodes 5 to 7 are taken and dropped without output.
//   Output stream: one ASCII character per item, most significant first,
//   tlast on the final character. Leading zeros are suppressed; zero gives '0'.
//   Steps: decimal items run a shift-add-3 converter, one value bit per cycle;
//   hex items load their nibbles when taken. Leading zero digits are then
//   dropped one per cycle, and characters leave one per cycle while the
//   receiver takes them.
//   A new item is taken once the last character sits in the output register.
//   Reset clears the controller and the output valid; no clearing pass.
//   When the receiver stalls, the output item holds and character output waits.
module integer_to_ascii_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ita_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] value, [34:32] opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ita_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] character
  output logic                             out_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  localparam int VW    = ita_pkg::VALUE_WIDTH;
  localparam int DIG_W = ita_pkg::DIG_W;
  localparam int NDIG  = ita_pkg::NDIG;
  localparam int CNT_W = ita_pkg::CNT_W;
  localparam int BIT_W = ita_pkg::BIT_W;

  logic [2:0]                     state_r, state_nxt;
  logic [VW-1:0]                  bin_r, bin_nxt;
  logic [DIG_W-1:0]               dig_r, dig_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [BIT_W-1:0]               bit_r, bit_nxt;
  logic [1:0]                     pre_r, pre_nxt;
  logic                           neg_r, neg_nxt;
  logic                           ptr_r, ptr_nxt;
  logic                           upper_r, upper_nxt;
  logic                           ovalid_r, ovalid_nxt;
  logic [ita_pkg::CHAR_W-1:0]     ochar_r, ochar_nxt;
  logic                           olast_r, olast_nxt;

  logic [VW-1:0]                  in_value;
  logic [ita_pkg::OPCODE_W-1:0]   in_opcode;
  logic                           accept;
  logic                           can_load;
  logic                           is_neg;
  logic [VW-1:0]                  magnitude;
  logic [ita_pkg::HEX_W-1:0]      hex_val;
  logic [DIG_W-1:0]               dig_adj;
  logic [3:0]                     top_nib;

  assign in_value  = VW'(in_tdata[ita_pkg::IN_VALUE_W-1:0]);
  assign in_opcode = in_tdata[ita_pkg::IN_VALUE_W +: ita_pkg::OPCODE_W];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign can_load  = !ovalid_r || out_tready;
  assign is_neg    = (in_opcode == ita_pkg::OP_SDEC) && in_value[VW-1];
  assign magnitude = is_neg ? (~in_value + VW'(1)) : in_value;
  assign hex_val   = ita_pkg::HEX_W'(in_value);
  assign top_nib   = dig_r[DIG_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig_adj[i*4 +: 4] = (dig_r[i*4 +: 4] >= 4'd5) ? (dig_r[i*4 +: 4] + 4'd3)
                                                    : dig_r[i*4 +: 4];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    dig_nxt    = dig_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    pre_nxt    = pre_r;
    neg_nxt    = neg_r;
    ptr_nxt    = ptr_r;
    upper_nxt  = upper_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = is_neg;
          ptr_nxt   = (in_opcode == ita_pkg::OP_PTR);
          upper_nxt = (in_opcode == ita_pkg::OP_HEXU);
          bin_nxt   = magnitude;
          bit_nxt   = BIT_W'(VW - 1);
          case (in_opcode)
            ita_pkg::OP_SDEC, ita_pkg::OP_UDEC: begin
              dig_nxt   = '0;
              cnt_nxt   = CNT_W'(ita_pkg::DEC_DIGITS);
              pre_nxt   = is_neg ? 2'd1 : 2'd0;
              state_nxt = S_CONV;
            end
            ita_pkg::OP_HEXL, ita_pkg::OP_HEXU, ita_pkg::OP_PTR: begin
              dig_nxt   = '0;
              dig_nxt[DIG_W-1 -: ita_pkg::HEX_W] = hex_val;
              cnt_nxt   = CNT_W'(ita_pkg::HEX_DIGITS);
              pre_nxt   = (in_opcode == ita_pkg::OP_PTR) ? 2'd2 : 2'd0;
              state_nxt = S_SKIP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        dig_nxt = {dig_adj[DIG_W-2:0], bin_r[VW-1]};
        bin_nxt = {bin_r[VW-2:0], 1'b0};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_nib == 4'd0 && cnt_r > CNT_W'(1)) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          if (pre_r != 2'd0) begin
            olast_nxt = 1'b0;
            pre_nxt   = pre_r - 2'd1;
            if (neg_r) ochar_nxt = ita_pkg::CH_MINUS;
            else if (pre_r == 2'd2) ochar_nxt = ita_pkg::CH_ZERO;
            else ochar_nxt = ita_pkg::CH_X;
          end else begin
            ochar_nxt = ita_pkg::digit_char(top_nib, upper_r);
            olast_nxt = (cnt_r == CNT_W'(1));
            dig_nxt   = {dig_r[DIG_W-5:0], 4'd0};
            cnt_nxt   = cnt_r - CNT_W'(1);
            if (cnt_r == CNT_W'(1)) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      pre_r    <= 2'd0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      pre_r    <= pre_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    dig_r   <= dig_nxt;
    bit_r   <= bit_nxt;
    neg_r   <= neg_nxt;
    ptr_r   <= ptr_nxt;
    upper_r <= upper_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_SKIP) |-> cnt_r != '0)
    else $error("digit count empty while emitting");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && can_load && pre_r == 2'd0 && cnt_r == CNT_W'(1))
      |=> (state_r == S_IDLE && out_tlast && out_tvalid))
    else $error("final character not marked or controller not idle");

  a_pre_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && pre_r != 2'd0) |-> (neg_r || ptr_r))
    else $error("prefix pending without sign or pointer form");

  a_prefix_first: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == ita_pkg::OP_PTR)) |=> (pre_r == 2'd2 && state_r == S_SKIP))
    else $error("pointer prefix not armed");

  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && bit_r == '0) |=> state_r == S_SKIP)
    else $error("conversion did not end after the last bit");

endmodule
